// ===== hdl/stop_and_wait_crc8_receiver_unit_assert.svh =====
// Assertion macros used by the receiver's result queue RTL.
`ifndef STOP_AND_WAIT_CRC8_RECEIVER_UNIT_ASSERT_SVH
`define STOP_AND_WAIT_CRC8_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWC_ASSERT_HOLDS(name, clk_s, rstn_s, pre, post) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |-> (post)) \
    else $error("receiver assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWC_ASSERT_NEXT(name, clk_s, rstn_s, pre, post) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |=> (post)) \
    else $error("receiver assertion failed");

`endif

// ===== hdl/swcrc_pkg.sv =====
// Shared types, constants and tables of the stop-and-wait CRC-8 receiver.
package swcrc_pkg;

  localparam int POS_W       = 17;
  localparam int LEN_W       = 16;
  localparam int SEQ_W       = 16;
  localparam int RETRY_W     = 4;
  localparam int OUTQ_DEPTH  = 4;

  localparam logic [POS_W-1:0] POS_MAX       = '1;
  localparam logic [POS_W-1:0] HDR_BYTES     = 17'd5;
  localparam logic [POS_W-1:0] END_MARK_LEN  = 17'd7;
  localparam logic [POS_W-1:0] END_MARK_LAST = 17'd5;   // pos of 6th byte
  localparam logic [POS_W-1:0] ERR_MARK_LEN  = 17'd36;
  localparam logic [POS_W-1:0] ERR_MARK_LAST = 17'd35;

  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd3;

  localparam logic [7*8-1:0]  END_MARK = {"EOF\t\t\t", 8'h00};
  localparam logic [36*8-1:0] ERR_MARK = {"UNABLE", "_TO_", "COMPLETE", "_THE_", "OPERATION",
                                          "\t\t\t\n"};

  typedef enum logic [2:0] {
    VERDICT_ACK   = 3'd0,
    VERDICT_NACK  = 3'd1,
    VERDICT_ABORT = 3'd2,
    VERDICT_EOT   = 3'd3,
    VERDICT_SRV   = 3'd4
  } verdict_t;

  typedef struct packed {
    logic             is_verdict;
    logic [7:0]       payload_byte;
    logic [2:0]       verdict;
    logic [SEQ_W-1:0] frame_seq;
    logic             last;
  } result_t;

  // Results produced by one accepted request: cnt of 0, 1 or 2, in order r0, r1.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  localparam logic [7:0] CRC_TAB [256] = '{
    8'hea, 8'hd4, 8'h96, 8'ha8, 8'h12, 8'h2c, 8'h6e, 8'h50, 8'h7f, 8'h41, 8'h03, 8'h3d,
    8'h87, 8'hb9, 8'hfb, 8'hc5, 8'ha5, 8'h9b, 8'hd9, 8'he7, 8'h5d, 8'h63, 8'h21, 8'h1f,
    8'h30, 8'h0e, 8'h4c, 8'h72, 8'hc8, 8'hf6, 8'hb4, 8'h8a, 8'h74, 8'h4a, 8'h08, 8'h36,
    8'h8c, 8'hb2, 8'hf0, 8'hce, 8'he1, 8'hdf, 8'h9d, 8'ha3, 8'h19, 8'h27, 8'h65, 8'h5b,
    8'h3b, 8'h05, 8'h47, 8'h79, 8'hc3, 8'hfd, 8'hbf, 8'h81, 8'hae, 8'h90, 8'hd2, 8'hec,
    8'h56, 8'h68, 8'h2a, 8'h14, 8'hb3, 8'h8d, 8'hcf, 8'hf1, 8'h4b, 8'h75, 8'h37, 8'h09,
    8'h26, 8'h18, 8'h5a, 8'h64, 8'hde, 8'he0, 8'ha2, 8'h9c, 8'hfc, 8'hc2, 8'h80, 8'hbe,
    8'h04, 8'h3a, 8'h78, 8'h46, 8'h69, 8'h57, 8'h15, 8'h2b, 8'h91, 8'haf, 8'hed, 8'hd3,
    8'h2d, 8'h13, 8'h51, 8'h6f, 8'hd5, 8'heb, 8'ha9, 8'h97, 8'hb8, 8'h86, 8'hc4, 8'hfa,
    8'h40, 8'h7e, 8'h3c, 8'h02, 8'h62, 8'h5c, 8'h1e, 8'h20, 8'h9a, 8'ha4, 8'he6, 8'hd8,
    8'hf7, 8'hc9, 8'h8b, 8'hb5, 8'h0f, 8'h31, 8'h73, 8'h4d, 8'h58, 8'h66, 8'h24, 8'h1a,
    8'ha0, 8'h9e, 8'hdc, 8'he2, 8'hcd, 8'hf3, 8'hb1, 8'h8f, 8'h35, 8'h0b, 8'h49, 8'h77,
    8'h17, 8'h29, 8'h6b, 8'h55, 8'hef, 8'hd1, 8'h93, 8'had, 8'h82, 8'hbc, 8'hfe, 8'hc0,
    8'h7a, 8'h44, 8'h06, 8'h38, 8'hc6, 8'hf8, 8'hba, 8'h84, 8'h3e, 8'h00, 8'h42, 8'h7c,
    8'h53, 8'h6d, 8'h2f, 8'h11, 8'hab, 8'h95, 8'hd7, 8'he9, 8'h89, 8'hb7, 8'hf5, 8'hcb,
    8'h71, 8'h4f, 8'h0d, 8'h33, 8'h1c, 8'h22, 8'h60, 8'h5e, 8'he4, 8'hda, 8'h98, 8'ha6,
    8'h01, 8'h3f, 8'h7d, 8'h43, 8'hf9, 8'hc7, 8'h85, 8'hbb, 8'h94, 8'haa, 8'he8, 8'hd6,
    8'h6c, 8'h52, 8'h10, 8'h2e, 8'h4e, 8'h70, 8'h32, 8'h0c, 8'hb6, 8'h88, 8'hca, 8'hf4,
    8'hdb, 8'he5, 8'ha7, 8'h99, 8'h23, 8'h1d, 8'h5f, 8'h61, 8'h9f, 8'ha1, 8'he3, 8'hdd,
    8'h67, 8'h59, 8'h1b, 8'h25, 8'h0a, 8'h34, 8'h76, 8'h48, 8'hf2, 8'hcc, 8'h8e, 8'hb0,
    8'hd0, 8'hee, 8'hac, 8'h92, 8'h28, 8'h16, 8'h54, 8'h6a, 8'h45, 8'h7b, 8'h39, 8'h07,
    8'hbd, 8'h83, 8'hc1, 8'hff
  };

  // Byte i of the end-of-transfer marker (i below 7).
  function automatic logic [7:0] end_mark_byte(input logic [2:0] i);
    logic [2:0] k;
    k = 3'd6 - i;
    return END_MARK[{k, 3'b000} +: 8];
  endfunction

  // Byte i of the server-error marker (i below 36).
  function automatic logic [7:0] err_mark_byte(input logic [5:0] i);
    logic [5:0] k;
    k = 6'd35 - i;
    return ERR_MARK[{k, 3'b000} +: 8];
  endfunction

endpackage

// ===== hdl/swcrc_core.sv =====
// Frame parser: header capture, chained CRC-8, marker match and verdict.
module swcrc_core
  import swcrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         rx_byte,
  input  logic               frame_end,
  input  logic               cfg_we,
  input  logic [RETRY_W-1:0] cfg_wdata,
  output push_t              push
);

  logic [POS_W-1:0]   pos_r,   pos_nxt;
  logic [LEN_W-1:0]   plen_r,  plen_nxt;
  logic [SEQ_W-1:0]   hseq_r,  hseq_nxt;
  logic [7:0]         hcrc_r,  hcrc_nxt;
  logic [7:0]         rcrc_r,  rcrc_nxt;
  logic [7:0]         ccrc_r,  ccrc_nxt;
  logic [SEQ_W-1:0]   eseq_r,  eseq_nxt;
  logic [RETRY_W-1:0] retry_r, retry_nxt;
  logic               endm_r,  endm_nxt;
  logic               errm_r,  errm_nxt;
  logic [RETRY_W-1:0] limit_r;

  logic               is_pay;
  logic               full_len;
  logic [RETRY_W-1:0] retry_inc;
  logic [SEQ_W-1:0]   vseq;
  verdict_t           vcode;
  result_t            pay_res, ver_res;

  always_comb begin
    pos_nxt   = pos_r;
    plen_nxt  = plen_r;
    hseq_nxt  = hseq_r;
    hcrc_nxt  = hcrc_r;
    rcrc_nxt  = rcrc_r;
    ccrc_nxt  = ccrc_r;
    eseq_nxt  = eseq_r;
    retry_nxt = retry_r;
    endm_nxt  = endm_r;
    errm_nxt  = errm_r;
    vcode     = VERDICT_NACK;
    retry_inc = retry_r + RETRY_W'(1);

    if (pos_r < END_MARK_LEN && rx_byte != end_mark_byte(pos_r[2:0])) begin
      endm_nxt = 1'b0;
    end
    if (pos_r < ERR_MARK_LEN && rx_byte != err_mark_byte(pos_r[5:0])) begin
      errm_nxt = 1'b0;
    end

    // Header bytes, little-endian fields
    if (pos_r == 17'd0) begin
      plen_nxt[7:0] = rx_byte;
    end else if (pos_r == 17'd1) begin
      plen_nxt[15:8] = rx_byte;
    end else if (pos_r == 17'd2) begin
      hseq_nxt[7:0] = rx_byte;
    end else if (pos_r == 17'd3) begin
      hseq_nxt[15:8] = rx_byte;
    end else if (pos_r == 17'd4) begin
      hcrc_nxt = rx_byte;
    end
    // header seq as seen with this byte, kept for the verdict
    vseq = hseq_nxt;

    is_pay = (pos_r >= HDR_BYTES) && (pos_r < HDR_BYTES + POS_W'(plen_r));
    if (is_pay) begin
      rcrc_nxt = CRC_TAB[rcrc_r ^ rx_byte];
    end

    if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + POS_W'(1);
    end

    // frame length >= 5 + length, written as pos >= 4 + length
    full_len = pos_r >= (POS_W'(4) + POS_W'(plen_nxt));

    if (frame_end) begin
      if (endm_nxt && pos_r >= END_MARK_LAST) begin
        vcode     = VERDICT_EOT;
        ccrc_nxt  = '0;
        eseq_nxt  = '0;
        retry_nxt = '0;
      end else if (errm_nxt && pos_r >= ERR_MARK_LAST) begin
        vcode     = VERDICT_SRV;
        ccrc_nxt  = '0;
        eseq_nxt  = '0;
        retry_nxt = '0;
      end else if (full_len && hcrc_nxt == rcrc_nxt && hseq_nxt == eseq_r) begin
        vcode     = VERDICT_ACK;
        ccrc_nxt  = rcrc_nxt;
        eseq_nxt  = eseq_r + SEQ_W'(1);
        retry_nxt = '0;
      end else if (retry_inc >= limit_r) begin
        vcode     = VERDICT_ABORT;
        ccrc_nxt  = '0;
        eseq_nxt  = '0;
        retry_nxt = '0;
      end else begin
        vcode     = VERDICT_NACK;
        retry_nxt = retry_inc;
      end
      // fresh frame
      pos_nxt  = '0;
      plen_nxt = '0;
      hseq_nxt = '0;
      hcrc_nxt = '0;
      rcrc_nxt = ccrc_nxt;
      endm_nxt = 1'b1;
      errm_nxt = 1'b1;
    end
  end

  always_comb begin
    pay_res              = '0;
    pay_res.payload_byte = rx_byte;
    pay_res.last         = ~frame_end;
    ver_res              = '0;
    ver_res.is_verdict   = 1'b1;
    ver_res.verdict      = vcode;
    ver_res.frame_seq    = vseq;
    ver_res.last         = 1'b1;

    push = '0;
    if (accept) begin
      if (is_pay) begin
        push.r0 = pay_res;
        push.r1 = ver_res;
        push.cnt = frame_end ? 2'd2 : 2'd1;
      end else if (frame_end) begin
        push.r0  = ver_res;
        push.cnt = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      plen_r  <= '0;
      hseq_r  <= '0;
      hcrc_r  <= '0;
      rcrc_r  <= '0;
      ccrc_r  <= '0;
      eseq_r  <= '0;
      retry_r <= '0;
      endm_r  <= 1'b1;
      errm_r  <= 1'b1;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      plen_r  <= plen_nxt;
      hseq_r  <= hseq_nxt;
      hcrc_r  <= hcrc_nxt;
      rcrc_r  <= rcrc_nxt;
      ccrc_r  <= ccrc_nxt;
      eseq_r  <= eseq_nxt;
      retry_r <= retry_nxt;
      endm_r  <= endm_nxt;
      errm_r  <= errm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

endmodule

// ===== hdl/swcrc_outq.sv =====
// Result queue: takes up to two results per cycle, hands out one when out_stall is low.
`include "stop_and_wait_crc8_receiver_unit_assert.svh"

module swcrc_outq
  import swcrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  localparam int PTR_W = $clog2(OUTQ_DEPTH);
  localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

  result_t          mem_r [OUTQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;
  logic             pop;

  assign out_valid = count_r != '0;
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid & ~out_stall;
  // room for the worst case of two results
  assign full      = count_r > CNT_W'(OUTQ_DEPTH - 2);

  assign wr_ptr_p1  = wr_ptr_r + PTR_W'(1);
  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign count_nxt  = count_r + CNT_W'(push.cnt) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `SWC_ASSERT_HOLDS(a_no_overflow, clk, rst_n, push.cnt != 2'd0,
    count_r <= CNT_W'(OUTQ_DEPTH) - CNT_W'(push.cnt))
  `SWC_ASSERT_HOLDS(a_ptr_track, clk, rst_n, 1'b1, wr_ptr_r == rd_ptr_r + PTR_W'(count_r))
  `SWC_ASSERT_NEXT(a_pair_count, clk, rst_n, push.cnt == 2'd2 && !pop,
    count_r == $past(count_r) + CNT_W'(2))

endmodule

// ===== hdl/stop_and_wait_crc8_receiver_unit.sv =====
// Top level of the stop-and-wait ARQ receiver with chained CRC-8.
//
// Input channel (in_valid / in_stall): one datagram byte per request, with
// in_frame_end on the last byte. Every frame starts with a 5-byte header:
// length (LE16), sequence (LE16), sender CRC.
// Result channel (out_valid / out_stall): payload bytes are forwarded as
// results with is_verdict low; each frame end adds one verdict result
// (ack, nack, abort, end of transfer, server error) carrying the header seq.
// out_last flags the final result caused by a given input byte.
// Config: cfg_we writes cfg_wdata into retry_limit (reset value 3); the user
// writes it only while idle, which the block itself does not enforce.
// Throughput: one byte per cycle while in_stall is low.
// The whole parse, table lookup and verdict compare sit between the state
// registers and a 4-entry result queue.
// A byte that yields two results (last payload byte with frame end) fills
// the queue twice as fast as it drains, so in_stall rises when fewer than
// two entries are free. If the downstream stalls, the queue fills and
// in_stall follows. Reset (synchronous, rst_n low) empties the queue and
// starts a fresh transfer; no clearing pass is needed.
module stop_and_wait_crc8_receiver_unit
  import swcrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // byte requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_frame_end,
  // results
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_is_verdict,
  output logic [7:0]         out_payload_byte,
  output logic [2:0]         out_verdict,
  output logic [SEQ_W-1:0]   out_frame_seq,
  output logic               out_last,
  // retry limit register
  input  logic               cfg_we,
  input  logic [RETRY_W-1:0] cfg_wdata
);

  logic    in_accept;
  logic    q_full;
  push_t   push;
  result_t out_res;

  // stall depends on queue occupancy only
  assign in_stall  = q_full;
  assign in_accept = in_valid & ~q_full;

  swcrc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .rx_byte   (in_rx_byte),
    .frame_end (in_frame_end),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push)
  );

  swcrc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_is_verdict   = out_res.is_verdict;
  assign out_payload_byte = out_res.payload_byte;
  assign out_verdict      = out_res.verdict;
  assign out_frame_seq    = out_res.frame_seq;
  assign out_last         = out_res.last;

endmodule
